>>> rtl/gang_edf_job_scheduler_core_macros.svh
// Assertion macros for the gang EDF scheduler checker
`ifndef GANG_EDF_JOB_SCHEDULER_CORE_MACROS_SVH
`define GANG_EDF_JOB_SCHEDULER_CORE_MACROS_SVH
// assert that a condition implies a consequent in the same cycle
`define GES_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// assert that a condition implies a consequent in the next cycle
`define GES_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

>>> rtl/ges_pkg.sv
// ----------------------------------------------------------------------------
// ges_pkg
// Shared types and constants of the gang EDF job scheduler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package ges_pkg;
    localparam int NUM_KERNELS = 4;
    localparam int KSLOTS      = 4;
    localparam int IDX_W       = 2;
    localparam int CNT_W       = 3;

    localparam logic [1:0] OP_RELEASE = 2'd0;
    localparam logic [1:0] OP_TICK    = 2'd1;

    localparam logic [1:0] ST_INIT    = 2'd0;
    localparam logic [1:0] ST_READY   = 2'd1;
    localparam logic [1:0] ST_RUNNING = 2'd2;
    localparam logic [1:0] ST_TERM    = 2'd3;

    localparam logic [1:0] STS_OK      = 2'd0;
    localparam logic [1:0] STS_INVALID = 2'd1;
    localparam logic [1:0] STS_BUSY    = 2'd2;
    localparam logic [1:0] STS_FULL    = 2'd3;

    localparam logic [2:0] REG_BUDGET = 3'd0;
    localparam logic [2:0] REG_POLICY = 3'd1;
    localparam logic [2:0] REG_DL0    = 3'd2;
    localparam logic [2:0] REG_DL3    = 3'd5;
    localparam logic [2:0] REG_COST   = 3'd6;

    // job entry: kernel id and priority
    typedef struct packed {
        logic [1:0]  id;
        logic [31:0] prio;
    } job_t;

    typedef enum logic [3:0] {
        S_IDLE, S_REL, S_DRD, S_DCHK, S_PRD, S_IWAIT, S_ISH, S_SEL, S_SELRD,
        S_FIN, S_OUT
    } state_t;
endpackage

>>> rtl/ges_ram.sv
// ----------------------------------------------------------------------------
// ges_ram
// Single-port-write, single-read job memory with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module ges_ram import ges_pkg::*; (
    input  logic             aclk,
    input  logic             we,
    input  logic [IDX_W-1:0] waddr,
    input  job_t             wdata,
    input  logic [IDX_W-1:0] raddr,
    output job_t             rdata
);
    job_t mem [KSLOTS];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> rtl/gang_edf_job_scheduler_core.sv
// ----------------------------------------------------------------------------
// gang_edf_job_scheduler_core
// Gang scheduler: release, schedule tick and query over a sorted job list.
// ----------------------------------------------------------------------------
// One item is processed at a time. A tick walks the job list held in a
// registered-read memory: it drops terminated jobs, inserts each pending job
// in sorted order and then makes the selection. The result waits in an
// output register and the next item is taken once it is delivered.
`timescale 1ns / 1ps
module gang_edf_job_scheduler_core import ges_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [2:0]  s_kernel_id,
    input  logic [31:0] s_now_time,
    input  logic [3:0]  s_terminated_mask,
    input  logic [3:0]  s_preempted_mask,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [1:0]  m_kernel_state,
    output logic [3:0]  m_run_mask,
    output logic [3:0]  m_started_mask,
    output logic [3:0]  m_stopped_mask,
    output logic [2:0]  m_active_count
);
    // configuration
    logic [7:0]  budget_reg;
    logic        policy_reg;
    logic [31:0] dl_reg [KSLOTS];
    logic [31:0] cost_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            budget_reg <= '0;
            policy_reg <= 1'b0;
            dl_reg[0]  <= 32'd10000;
            dl_reg[1]  <= 32'd100000;
            dl_reg[2]  <= 32'd200000;
            dl_reg[3]  <= 32'd200000;
            cost_reg   <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_BUDGET: budget_reg <= cfg_data[7:0];
                REG_POLICY: policy_reg <= cfg_data[0];
                REG_COST:   cost_reg   <= cfg_data;
                default: begin
                    if (cfg_index >= REG_DL0 && cfg_index <= REG_DL3) begin
                        dl_reg[IDX_W'(cfg_index - REG_DL0)] <= cfg_data;
                    end
                end
            endcase
        end
    end

    // state registers
    state_t      state_reg, state_next;
    logic [CNT_W-1:0] jcnt_reg, jcnt_next, pcnt_reg, pcnt_next;
    logic [1:0]  kst_reg [KSLOTS];
    logic [1:0]  kst_next [KSLOTS];
    logic [3:0]  run_reg, run_next;
    logic [CNT_W-1:0] i_reg, i_next, w_reg, w_next;
    logic [7:0]  used_reg, used_next;
    logic [3:0]  sel_reg, sel_next;
    logic [1:0]  op_reg;
    logic [2:0]  kid_reg;
    logic [31:0] now_reg;
    logic [3:0]  term_reg, pre_reg;
    logic [1:0]  sts_reg, sts_next;
    job_t        ins_reg, ins_next;
    logic [3:0]  started_reg, started_next, stopped_reg, stopped_next;

    // memories: job list and pending stack
    logic        lwe, pwe;
    logic [IDX_W-1:0] lwa, lra, pwa, pra;
    job_t        lwd, pwd, lrd, prd;

    ges_ram u_list (.aclk(aclk), .we(lwe), .waddr(lwa), .wdata(lwd), .raddr(lra),
                    .rdata(lrd));
    ges_ram u_pend (.aclk(aclk), .we(pwe), .waddr(pwa), .wdata(pwd), .raddr(pra),
                    .rdata(prd));

    function automatic logic s_kid_ok(input logic [2:0] k);
        return k < 3'(NUM_KERNELS);
    endfunction

    logic        kvalid;
    logic [1:0]  kidx;
    logic [7:0]  jcost;
    logic [8:0]  sum;
    assign kvalid = s_kid_ok(kid_reg);
    assign kidx   = kid_reg[1:0];
    assign jcost  = cost_reg[8*lrd.id +: 8];
    assign sum    = {1'b0, used_reg} + {1'b0, jcost};

    // next-state and datapath
    always_comb begin
        state_next   = state_reg;
        jcnt_next    = jcnt_reg;
        pcnt_next    = pcnt_reg;
        kst_next     = kst_reg;
        run_next     = run_reg;
        i_next       = i_reg;
        w_next       = w_reg;
        used_next    = used_reg;
        sel_next     = sel_reg;
        sts_next     = sts_reg;
        ins_next     = ins_reg;
        started_next = started_reg;
        stopped_next = stopped_reg;
        lwe = 1'b0; lwa = w_reg[IDX_W-1:0]; lwd = lrd;
        lra = i_reg[IDX_W-1:0];
        pwe = 1'b0; pwa = pcnt_reg[IDX_W-1:0]; pwd = ins_reg;
        pra = IDX_W'(pcnt_reg - 3'd1);
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    sts_next = STS_OK;
                    started_next = '0;
                    stopped_next = '0;
                    i_next = '0;
                    w_next = '0;
                    state_next = (s_opcode == OP_RELEASE) ? S_REL :
                                 (s_opcode == OP_TICK) ? S_DRD : S_FIN;
                end
            end
            S_REL: begin
                if (!kvalid) begin
                    sts_next = STS_INVALID;
                end else if (kst_reg[kidx] == ST_READY || kst_reg[kidx] == ST_RUNNING) begin
                    sts_next = STS_BUSY;
                end else if (pcnt_reg >= 3'(NUM_KERNELS)) begin
                    sts_next = STS_FULL;
                end else begin
                    pwe = 1'b1;
                    pwd.id = kidx;
                    pwd.prio = policy_reg ? dl_reg[kidx] : now_reg + dl_reg[kidx];
                    kst_next[kidx] = ST_READY;
                    pcnt_next = pcnt_reg + 3'd1;
                end
                state_next = S_FIN;
            end
            // drop pass: read entry i, compact into position w
            S_DRD: begin
                state_next = (i_reg < jcnt_reg) ? S_DCHK : S_PRD;
                if (i_reg >= jcnt_reg) begin
                    jcnt_next = w_reg;
                end
            end
            S_DCHK: begin
                if (term_reg[lrd.id]) begin
                    kst_next[lrd.id] = ST_TERM;
                    run_next[lrd.id] = 1'b0;
                end else begin
                    if (pre_reg[lrd.id]) begin
                        kst_next[lrd.id] = ST_READY;
                        run_next[lrd.id] = 1'b0;
                    end
                    lwe = 1'b1;
                    w_next = w_reg + 3'd1;
                end
                i_next = i_reg + 3'd1;
                state_next = S_DRD;
            end
            // pop one pending job; pra already addresses the top
            S_PRD: begin
                if (pcnt_reg == '0) begin
                    i_next = '0;
                    used_next = '0;
                    sel_next = '0;
                    state_next = S_SEL;
                end else begin
                    state_next = S_IWAIT;
                end
            end
            S_IWAIT: begin
                ins_next = prd;
                pcnt_next = pcnt_reg - 3'd1;
                if (jcnt_reg >= 3'(NUM_KERNELS)) begin
                    sts_next = STS_FULL;
                    state_next = S_PRD;
                end else begin
                    i_next = jcnt_reg;
                    w_next = '0;
                    state_next = S_ISH;
                end
            end
            // shift up while entry i-1 has priority >= new one
            S_ISH: begin
                lra = IDX_W'(i_reg - 3'd1);
                if (i_reg == '0) begin
                    lwe = 1'b1; lwa = '0; lwd = ins_reg;
                    jcnt_next = jcnt_reg + 3'd1;
                    state_next = S_PRD;
                end else if (w_reg[0]) begin
                    w_next = '0;
                    if (lrd.prio >= ins_reg.prio) begin
                        lwe = 1'b1; lwa = i_reg[IDX_W-1:0]; lwd = lrd;
                        i_next = i_reg - 3'd1;
                    end else begin
                        lwe = 1'b1; lwa = i_reg[IDX_W-1:0]; lwd = ins_reg;
                        jcnt_next = jcnt_reg + 3'd1;
                        state_next = S_PRD;
                    end
                end else begin
                    w_next = 3'd1;
                end
            end
            S_SEL: begin
                if (i_reg < jcnt_reg && used_reg < budget_reg) begin
                    state_next = S_SELRD;
                end else begin
                    started_next = sel_reg & ~run_reg;
                    stopped_next = run_reg & ~sel_reg;
                    for (int k = 0; k < KSLOTS; k++) begin
                        if (sel_reg[k] && !run_reg[k]) kst_next[k] = ST_RUNNING;
                        if (run_reg[k] && !sel_reg[k]) kst_next[k] = ST_READY;
                    end
                    run_next = sel_reg;
                    state_next = S_FIN;
                end
            end
            S_SELRD: begin
                if (sum <= {1'b0, budget_reg}) begin
                    used_next = sum[7:0];
                    sel_next[lrd.id] = 1'b1;
                end
                i_next = i_reg + 3'd1;
                state_next = S_SEL;
            end
            S_FIN: begin
                if (op_reg != OP_TICK && op_reg != OP_RELEASE && !kvalid) begin
                    sts_next = STS_INVALID;
                end
                state_next = S_OUT;
            end
            S_OUT: begin
                if (m_ready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            jcnt_reg  <= '0;
            pcnt_reg  <= '0;
            run_reg   <= '0;
            for (int k = 0; k < KSLOTS; k++) kst_reg[k] <= ST_INIT;
        end else begin
            state_reg <= state_next;
            jcnt_reg  <= jcnt_next;
            pcnt_reg  <= pcnt_next;
            run_reg   <= run_next;
            kst_reg   <= kst_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        i_reg <= i_next; w_reg <= w_next; used_reg <= used_next; sel_reg <= sel_next;
        sts_reg <= sts_next; ins_reg <= ins_next;
        started_reg <= started_next; stopped_reg <= stopped_next;
        if (state_reg == S_IDLE && s_valid) begin
            op_reg <= s_opcode; kid_reg <= s_kernel_id; now_reg <= s_now_time;
            term_reg <= s_terminated_mask; pre_reg <= s_preempted_mask;
        end
    end

    // outputs
    assign s_ready        = (state_reg == S_IDLE);
    assign m_valid        = (state_reg == S_OUT);
    assign m_status       = sts_reg;
    assign m_kernel_state = kvalid ? kst_reg[kidx] : ST_INIT;
    assign m_run_mask     = run_reg;
    assign m_started_mask = started_reg;
    assign m_stopped_mask = stopped_reg;
    assign m_active_count = jcnt_reg;
endmodule

>>> rtl/ges_checker.sv
// ----------------------------------------------------------------------------
// ges_checker
// Port-level checks of the gang EDF scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "gang_edf_job_scheduler_core_macros.svh"
module ges_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [3:0] m_run_mask,
    input logic [3:0] m_started_mask,
    input logic [3:0] m_stopped_mask,
    input logic [2:0] m_active_count
);
    // one transaction in flight at a time
    `GES_ASSERT_IMPL(a_excl, aclk, aresetn, m_valid, !s_ready)
    // a pending result holds
    `GES_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid)
    // started kernels run, stopped ones do not
    `GES_ASSERT_IMPL(a_edges, aclk, aresetn, m_valid,
        ((m_started_mask & ~m_run_mask) == 4'd0) && ((m_stopped_mask & m_run_mask) == 4'd0))
    // list never exceeds the kernel count
    `GES_ASSERT_IMPL(a_count, aclk, aresetn, m_valid, m_active_count <= 3'd4)
endmodule

bind gang_edf_job_scheduler_core ges_checker u_ges_checker (.*);
